>>> design/scc_pkg.sv
`default_nettype none
package scc_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);

  localparam logic [1:0] StatusStored  = 2'd0;
  localparam logic [1:0] StatusDropped = 2'd1;
  localparam logic [1:0] StatusCount   = 2'd2;

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdCount   = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [VtxW-1:0] edge_source;
    logic [VtxW-1:0] edge_target;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] component_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic add_edge;     // store the input edge
    logic clear_visit;  // clear visited marks and walk stack
    logic clear_finish; // reset finish depth, component count and clear row
    logic load_outer;   // first pass outer index to zero
    logic load_outer2;  // second pass outer index to finish depth
    logic pass2;        // walk the reverse matrix
    logic fetch_outer;  // read the next second pass start from finish order
    logic outer_try;    // try outer vertex as a new start
    logic fetch_row;    // read the stack-top rows and the entry below the top
    logic walk_step;    // one step of the walk at stack top
    logic clear_graph;  // clear one row of both matrices
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic outer_done;   // outer loop finished
    logic stack_empty;  // walk finished
    logic clear_done;   // clearing the last row
  } sts_t;

endpackage
`default_nettype wire

>>> design/scc_datapath.sv
`default_nettype none
module scc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire scc_pkg::ctl_t               ctl,
  input  wire logic [scc_pkg::VtxW-1:0]    src,
  input  wire logic [scc_pkg::VtxW-1:0]    dst,
  input  wire logic [scc_pkg::CntW-1:0]    n_act,
  output scc_pkg::sts_t                    sts,
  output logic [scc_pkg::CntW-1:0]         count
);

  localparam int M = scc_pkg::MaxVertices;
  localparam int VW = scc_pkg::VtxW;
  localparam int CW = scc_pkg::CntW;

  logic [M-1:0] fwd [M];
  logic [M-1:0] rev [M];
  logic [M-1:0] fwd_q;
  logic [M-1:0] rev_q;
  logic [M-1:0] visited;
  logic [VW-1:0] finish_order [M];
  logic [VW-1:0] walk_stack [M];
  logic [CW-1:0] finish_depth;
  logic [CW-1:0] top;
  logic [CW-1:0] outer;
  logic [VW-1:0] top_v;
  logic [VW-1:0] below_v;
  logic [VW-1:0] ov_q;
  logic [VW-1:0] clr_row;

  // mask of vertices below active count
  logic [M-1:0] act_mask;
  always_comb begin
    for (int i = 0; i < M; i++) begin
      act_mask[i] = (CW'(i) < n_act);
    end
  end

  // fetched row of the stack-top vertex, unvisited neighbors
  logic [M-1:0] cand;
  logic found;
  logic push;
  logic [VW-1:0] u;
  assign cand = (ctl.pass2 ? rev_q : fwd_q) & ~visited & act_mask;
  assign found = |cand;
  assign push = found && (top < CW'(M));
  always_comb begin
    u = '0;
    for (int i = M - 1; i >= 0; i--) begin
      if (cand[i]) u = VW'(i);
    end
  end

  // outer vertex candidate
  logic [VW-1:0] ov;
  assign ov = ctl.pass2 ? ov_q : outer[VW-1:0];

  assign sts.outer_done  = ctl.pass2 ? (outer == '0) : (outer >= n_act);
  assign sts.stack_empty = (top == '0);
  assign sts.clear_done  = (clr_row == VW'(M - 1));

  // matrices, cleared one row a cycle
  always_ff @(posedge clk) begin
    if (ctl.add_edge) begin
      fwd[src][dst] <= 1'b1;
      rev[dst][src] <= 1'b1;
    end else if (ctl.clear_graph) begin
      fwd[clr_row] <= '0;
      rev[clr_row] <= '0;
    end
  end

  // registered reads of the matrices and stacks
  always_ff @(posedge clk) begin
    if (ctl.fetch_row) begin
      fwd_q <= fwd[top_v];
      rev_q <= rev[top_v];
      below_v <= walk_stack[top[VW-1:0] - VW'(2)];
    end
    if (ctl.fetch_outer) begin
      ov_q <= finish_order[outer[VW-1:0] - VW'(1)];
    end
  end

  // stacks
  always_ff @(posedge clk) begin
    if (ctl.outer_try && !visited[ov]) begin
      walk_stack[0] <= ov;
    end else if (ctl.walk_step && push) begin
      walk_stack[top[VW-1:0]] <= u;
    end
    if (ctl.walk_step && !push && !ctl.pass2 && finish_depth < CW'(M)) begin
      finish_order[finish_depth[VW-1:0]] <= top_v;
    end
  end

  // control registers of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      top <= '0;
      top_v <= '0;
      finish_depth <= '0;
      count <= '0;
      outer <= '0;
      clr_row <= '0;
    end else begin
      if (ctl.clear_visit) begin
        visited <= '0;
        top <= '0;
      end
      if (ctl.clear_finish) begin
        finish_depth <= '0;
        count <= '0;
        clr_row <= '0;
      end
      if (ctl.load_outer) outer <= '0;
      if (ctl.load_outer2) outer <= finish_depth;
      if (ctl.outer_try) begin
        if (!visited[ov]) begin
          visited[ov] <= 1'b1;
          top <= CW'(1);
          top_v <= ov;
          if (ctl.pass2) count <= count + CW'(1);
        end else begin
          outer <= ctl.pass2 ? outer - CW'(1) : outer + CW'(1);
        end
      end
      if (ctl.walk_step) begin
        if (push) begin
          visited[u] <= 1'b1;
          top <= top + CW'(1);
          top_v <= u;
        end else begin
          top <= top - CW'(1);
          top_v <= below_v;
          if (!ctl.pass2 && finish_depth < CW'(M)) begin
            finish_depth <= finish_depth + CW'(1);
          end
          if (top == CW'(1)) begin
            outer <= ctl.pass2 ? outer - CW'(1) : outer + CW'(1);
          end
        end
      end
      if (ctl.clear_graph) clr_row <= clr_row + VW'(1);
    end
  end

endmodule
`default_nettype wire

>>> design/scc_control.sv
`default_nettype none
module scc_control (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     cmd,
  input  wire logic                     edge_ok,
  input  wire scc_pkg::sts_t            sts,
  output scc_pkg::ctl_t                 ctl,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status_code
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TRY1   = 9'b000000010,
    S_FETCH1 = 9'b000000100,
    S_WALK1  = 9'b000001000,
    S_PICK2  = 9'b000010000,
    S_TRY2   = 9'b000100000,
    S_FETCH2 = 9'b001000000,
    S_WALK2  = 9'b010000000,
    S_CLEAR  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic init_clear;

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (start && cmd == scc_pkg::CmdCount) begin
          ctl.clear_visit = 1'b1;
          ctl.clear_finish = 1'b1;
          ctl.load_outer = 1'b1;
          state_next = S_TRY1;
        end else if (start && edge_ok) begin
          ctl.add_edge = 1'b1;
        end
      end
      S_TRY1: begin
        if (sts.outer_done) begin
          ctl.clear_visit = 1'b1;
          ctl.load_outer2 = 1'b1;
          state_next = S_PICK2;
        end else begin
          ctl.outer_try = 1'b1;
          state_next = S_FETCH1;
        end
      end
      S_FETCH1: begin
        if (sts.stack_empty) begin
          state_next = S_TRY1;
        end else begin
          ctl.fetch_row = 1'b1;
          state_next = S_WALK1;
        end
      end
      S_WALK1: begin
        ctl.walk_step = 1'b1;
        state_next = S_FETCH1;
      end
      S_PICK2: begin
        ctl.pass2 = 1'b1;
        if (sts.outer_done) begin
          state_next = S_CLEAR;
        end else begin
          ctl.fetch_outer = 1'b1;
          state_next = S_TRY2;
        end
      end
      S_TRY2: begin
        ctl.pass2 = 1'b1;
        ctl.outer_try = 1'b1;
        state_next = S_FETCH2;
      end
      S_FETCH2: begin
        ctl.pass2 = 1'b1;
        if (sts.stack_empty) begin
          state_next = S_PICK2;
        end else begin
          ctl.fetch_row = 1'b1;
          state_next = S_WALK2;
        end
      end
      S_WALK2: begin
        ctl.pass2 = 1'b1;
        ctl.walk_step = 1'b1;
        state_next = S_FETCH2;
      end
      S_CLEAR: begin
        ctl.clear_graph = 1'b1;
        if (sts.clear_done) begin
          ctl.clear_visit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // reset starts with a clearing pass over the matrices
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // result strobe and status, none after the reset clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      init_clear <= 1'b1;
      status_code <= scc_pkg::StatusStored;
    end else begin
      done <= 1'b0;
      if (state == S_IDLE && start && cmd == scc_pkg::CmdAddEdge) begin
        done <= 1'b1;
        status_code <= edge_ok ? scc_pkg::StatusStored : scc_pkg::StatusDropped;
      end else if (state == S_CLEAR && sts.clear_done) begin
        init_clear <= 1'b0;
        if (!init_clear) begin
          done <= 1'b1;
          status_code <= scc_pkg::StatusCount;
        end
      end
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

>>> design/strongly_connected_component_count_unit.sv
`default_nettype none
// channel   | signals                         | transfer when
// ----------+---------------------------------+--------------------------
// input     | start, busy, in_item            | start && !busy
// result    | result_valid, out_item          | result_valid (one cycle)
// config    | cfg_valid, cfg_ready, cfg_data  | cfg_valid && cfg_ready
//
// an edge item is taken in idle; its result strobes the next cycle, busy stays low.
// a count keeps busy high while it walks the n active vertices in two passes:
// a row fetch and a step per push and per pop, a try of each start candidate
// in each pass, then a clearing of the matrices row by row.
// after reset busy is high while the matrices are cleared;
// vertex_count resets to 64. the receiver cannot stall.
module strongly_connected_component_count_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire scc_pkg::in_item_t   in_item,
  output logic                     busy,
  output logic                     result_valid,
  output scc_pkg::out_item_t       out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [6:0]          cfg_data
);

  logic [6:0] vertex_count;
  logic [scc_pkg::CntW-1:0] n_act;
  logic edge_ok;
  scc_pkg::ctl_t ctl;
  scc_pkg::sts_t sts;
  logic [1:0] status_code;
  logic [scc_pkg::CntW-1:0] count;

  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  assign n_act = (vertex_count > 7'(scc_pkg::MaxVertices))
                 ? scc_pkg::CntW'(scc_pkg::MaxVertices)
                 : scc_pkg::CntW'(vertex_count);
  assign edge_ok = (scc_pkg::CntW'(in_item.edge_source) < n_act)
                && (scc_pkg::CntW'(in_item.edge_target) < n_act);

  scc_control u_ctl (
    .clk(clk), .rst(rst), .start(start), .cmd(in_item.cmd),
    .edge_ok(edge_ok), .sts(sts), .ctl(ctl), .busy(busy),
    .done(result_valid), .status_code(status_code)
  );

  scc_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .src(in_item.edge_source),
    .dst(in_item.edge_target), .n_act(n_act), .sts(sts), .count(count)
  );

  assign out_item.status = status_code;
  assign out_item.component_count =
    (status_code == scc_pkg::StatusCount) ? count : '0;

endmodule
`default_nettype wire
